>>> hdl/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Request and response layouts, status and opcode codes, register indexes
// and the layout of one block table entry.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 64;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned HDR_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [HDR_W-1:0]  HEADER_RESET = 7'd24;
  localparam logic [ADDR_W-1:0] LIMIT_RESET  = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_LIMIT = 2'd0,
    REG_HEADER     = 2'd1
  } reg_idx_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOOP    = 2'd1,
    ST_OOM     = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL
  } state_e;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] payload_address;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] heap_limit_bytes;
    logic [HDR_W-1:0]  header_bytes;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic              free;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

>>> hdl/ffha_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> hdl/ffha_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ctrl: allocation sequencer
// Walks the block table one entry per cycle through a shared adder and a
// comparator, then updates the table, the entry count and the break.
// ----------------------------------------------------------------------------
module ffha_ctrl #(
  parameter int unsigned MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ffha_pkg::cfg_t                cfg_i,
  input  wire logic                          start_i,
  input  wire ffha_pkg::req_t                req_i,
  output logic                               busy_o,
  output logic                               done_o,
  output ffha_pkg::rsp_t                     rsp_o,
  output logic                               ram_re_o,
  output logic [$clog2(MAX_BLOCKS)-1:0]      ram_raddr_o,
  input  wire logic [ffha_pkg::ENTRY_W-1:0]  ram_rdata_i,
  output logic                               ram_we_o,
  output logic [$clog2(MAX_BLOCKS)-1:0]      ram_waddr_o,
  output logic [ffha_pkg::ENTRY_W-1:0]       ram_wdata_o
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW    = ffha_pkg::ADDR_W;

  ffha_pkg::state_e state_q, state_d;
  logic             op_q, op_d;
  logic [AW-1:0]    size_q, size_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [AW-1:0]    brk_q, brk_d;
  logic             done_q, done_d;
  ffha_pkg::rsp_t   rsp_q, rsp_d;

  ffha_pkg::entry_t          rd_entry;
  logic [ffha_pkg::HDR_W-1:0] hdr;
  logic [AW-1:0]             add_a;
  logic [AW:0]               sum;
  logic [AW+1:0]             tail_end;
  logic                      issue;
  logic                      hit;
  logic                      is_last;
  logic                      full;
  logic                      no_room;

  assign rd_entry = ffha_pkg::entry_t'(ram_rdata_i);
  assign hdr      = (cfg_i.header_bytes == '0) ? ffha_pkg::HDR_W'(1) : cfg_i.header_bytes;

  // Shared adder: entry start plus header during the scan, break plus header
  // when appending at the tail.
  assign add_a    = (state_q == ffha_pkg::S_TAIL) ? brk_q : rd_entry.start;
  assign sum      = {1'b0, add_a} + (AW + 1)'(hdr);
  assign tail_end = {1'b0, sum} + {2'b00, size_q};

  assign issue   = rd_cnt_q < count_q;
  assign hit     = pend_q && ((op_q == ffha_pkg::OP_ALLOC)
                   ? (rd_entry.free && (rd_entry.size >= size_q))
                   : (sum == {1'b0, addr_q}));
  assign is_last = (CNT_W'(cmp_idx_q) + CNT_W'(1)) == count_q;
  assign full    = count_q == CNT_W'(MAX_BLOCKS);
  assign no_room = full || (tail_end > {2'b00, cfg_i.heap_limit_bytes});

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffha_pkg::S_IDLE: begin
        if (start_i) begin
          if (req_i.opcode == ffha_pkg::OP_ALLOC) begin
            if (req_i.request_size != '0) begin
              state_d = (count_q == '0) ? ffha_pkg::S_TAIL : ffha_pkg::S_SCAN;
            end
          end else if ((req_i.block_address != '0) && (count_q != '0)) begin
            state_d = ffha_pkg::S_SCAN;
          end
        end
      end
      ffha_pkg::S_SCAN: begin
        if (hit) begin
          state_d = ffha_pkg::S_IDLE;
        end else if (!pend_q && !issue) begin
          state_d = (op_q == ffha_pkg::OP_ALLOC) ? ffha_pkg::S_TAIL : ffha_pkg::S_IDLE;
        end
      end
      ffha_pkg::S_TAIL: begin
        state_d = ffha_pkg::S_IDLE;
      end
      default: begin
        state_d = ffha_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    op_d        = op_q;
    size_d      = size_q;
    addr_d      = addr_q;
    rd_cnt_d    = rd_cnt_q;
    cmp_idx_d   = cmp_idx_q;
    pend_d      = 1'b0;
    count_d     = count_q;
    brk_d       = brk_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = rd_cnt_q[IDX_W-1:0];
    ram_we_o    = 1'b0;
    ram_waddr_o = cmp_idx_q;
    ram_wdata_o = {rd_entry.start, rd_entry.size, 1'b0};
    case (state_q)
      ffha_pkg::S_IDLE: begin
        if (start_i) begin
          op_d     = req_i.opcode;
          size_d   = req_i.request_size;
          addr_d   = req_i.block_address;
          rd_cnt_d = '0;
          rsp_d.payload_address = '0;
          if (req_i.opcode == ffha_pkg::OP_ALLOC) begin
            if (req_i.request_size == '0) begin
              done_d       = 1'b1;
              rsp_d.status = ffha_pkg::ST_NOOP;
            end
          end else if (req_i.block_address == '0) begin
            done_d       = 1'b1;
            rsp_d.status = ffha_pkg::ST_NOOP;
          end else if (count_q == '0) begin
            done_d       = 1'b1;
            rsp_d.status = ffha_pkg::ST_UNKNOWN;
          end
        end
      end
      ffha_pkg::S_SCAN: begin
        // Reads are issued one entry ahead of the compare.
        if (hit) begin
          done_d       = 1'b1;
          rsp_d.status = ffha_pkg::ST_OK;
          if (op_q == ffha_pkg::OP_ALLOC) begin
            ram_we_o              = 1'b1;
            rsp_d.payload_address = sum[AW-1:0];
          end else if (is_last) begin
            count_d = count_q - CNT_W'(1);
            brk_d   = rd_entry.start;
          end else begin
            ram_we_o    = 1'b1;
            ram_wdata_o = {rd_entry.start, rd_entry.size, 1'b1};
          end
        end else if (issue) begin
          ram_re_o  = 1'b1;
          rd_cnt_d  = rd_cnt_q + CNT_W'(1);
          cmp_idx_d = rd_cnt_q[IDX_W-1:0];
          pend_d    = 1'b1;
        end else if (!pend_q && (op_q == ffha_pkg::OP_FREE)) begin
          done_d       = 1'b1;
          rsp_d.status = ffha_pkg::ST_UNKNOWN;
        end
      end
      ffha_pkg::S_TAIL: begin
        done_d = 1'b1;
        if (no_room) begin
          rsp_d.status = ffha_pkg::ST_OOM;
        end else begin
          ram_we_o              = 1'b1;
          ram_waddr_o           = count_q[IDX_W-1:0];
          ram_wdata_o           = {brk_q, size_q, 1'b0};
          count_d               = count_q + CNT_W'(1);
          brk_d                 = tail_end[AW-1:0];
          rsp_d.status          = ffha_pkg::ST_OK;
          rsp_d.payload_address = sum[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffha_pkg::S_IDLE;
      pend_q  <= 1'b0;
      count_q <= '0;
      brk_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      count_q <= count_d;
      brk_q   <= brk_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    size_q    <= size_d;
    addr_q    <= addr_d;
    rd_cnt_q  <= rd_cnt_d;
    cmp_idx_q <= cmp_idx_d;
    rsp_q     <= rsp_d;
  end

  assign busy_o = state_q != ffha_pkg::S_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
`default_nettype wire

>>> hdl/first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top: first-fit heap allocator with a break pointer
// Configuration registers, the block table RAM and the allocation sequencer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its response is
// on rsp_o while done_o is high for exactly one cycle, and the receiver
// cannot stall it. A zero-size allocate, a null free, or a free with an
// empty table answers in the cycle after the request. Otherwise the
// sequencer walks the block table through the RAM's single read port, one
// entry per cycle, with each read issued one entry ahead of the compare.
// A free that matches nothing answers once the last entry is compared; an
// allocate with no free fit appends at the break or reports out of memory.
// busy is high while the table is walked or the tail appended, and low in
// the cycle that shows the response. The next request can be taken in the
// cycle the response is shown. Registers are to be written with cfg_we_i
// only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
  parameter int unsigned MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire ffha_pkg::req_t                   req_i,
  output logic                                  done_o,
  output ffha_pkg::rsp_t                        rsp_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ffha_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ffha_pkg::CFG_DAT_W-1:0]   cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);

  ffha_pkg::cfg_t cfg_q;

  logic                          ram_re;
  logic [IDX_W-1:0]              ram_raddr;
  logic [ffha_pkg::ENTRY_W-1:0]  ram_rdata;
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [ffha_pkg::ENTRY_W-1:0]  ram_wdata;

  // Writes to an index outside the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heap_limit_bytes <= ffha_pkg::LIMIT_RESET;
      cfg_q.header_bytes     <= ffha_pkg::HEADER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ffha_pkg::REG_HEAP_LIMIT: begin
          cfg_q.heap_limit_bytes <= cfg_wdata_i;
        end
        ffha_pkg::REG_HEADER: begin
          cfg_q.header_bytes <= cfg_wdata_i[ffha_pkg::HDR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  ffha_ram #(
    .WIDTH (ffha_pkg::ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ffha_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (start),
    .req_i       (req_i),
    .busy_o      (busy),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the first-fit heap allocator
// Drives allocate and free requests through the start/busy handshake with
// random gaps, rewrites the heap limit and header size between phases, and
// compares every response against a cycle-free table model or a fixed value.
// ----------------------------------------------------------------------------
module testbench;
  import ffha_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_BLOCKS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_data;
    req_t                 req;
    bit                   fixed;
    rsp_t                 rsp;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 req_i = '0;
  logic                 done_o;
  rsp_t                 rsp_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i = '0;

  // Model of the block table and the registers.
  logic [ADDR_W-1:0] blk_start [TABLE_DEPTH];
  logic [ADDR_W-1:0] blk_size  [TABLE_DEPTH];
  bit                blk_free  [TABLE_DEPTH];
  int unsigned       live_count = 0;
  logic [ADDR_W-1:0] break_ptr = '0;
  logic [ADDR_W-1:0] cfg_limit = LIMIT_RESET;
  logic [HDR_W-1:0]  cfg_header = HEADER_RESET;

  rsp_t        pending_responses[$];
  dir_row_t    directed_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned quiet_left = 0;

  first_fit_heap_allocator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] header_len();
    return (cfg_header == '0) ? 64'd1 : {57'd0, cfg_header};
  endfunction

  function automatic rsp_t predict_response(input req_t r);
    rsp_t        res;
    logic [63:0] hdr;
    logic [63:0] tail;
    bit          hit;
    int unsigned idx;
    res.payload_address = '0;
    res.status = ST_OK;
    hit = 1'b0;
    hdr = header_len();
    if (r.opcode == OP_ALLOC) begin
      if (r.request_size == '0) begin
        res.status = ST_NOOP;
      end else begin
        for (idx = 0; idx < live_count && !hit; idx++) begin
          if (blk_free[idx] && blk_size[idx] >= r.request_size) begin
            blk_free[idx] = 1'b0;
            res.payload_address = 32'({32'd0, blk_start[idx]} + hdr);
            hit = 1'b1;
          end
        end
        if (!hit) begin
          // The end of the new block is formed in 64 bits so it never wraps.
          tail = {32'd0, break_ptr} + hdr + {32'd0, r.request_size};
          if (live_count >= TABLE_DEPTH || tail > {32'd0, cfg_limit}) begin
            res.status = ST_OOM;
          end else begin
            blk_start[live_count] = break_ptr;
            blk_size[live_count] = r.request_size;
            blk_free[live_count] = 1'b0;
            live_count++;
            res.payload_address = 32'({32'd0, break_ptr} + hdr);
            break_ptr = tail[31:0];
          end
        end
      end
    end else begin
      if (r.block_address == '0) begin
        res.status = ST_NOOP;
      end else begin
        for (idx = 0; idx < live_count && !hit; idx++) begin
          if ({32'd0, blk_start[idx]} + hdr == {32'd0, r.block_address}) begin
            hit = 1'b1;
            if (idx + 1 == live_count) begin
              break_ptr = blk_start[idx];
              live_count--;
            end else begin
              blk_free[idx] = 1'b1;
            end
          end
        end
        if (!hit) res.status = ST_UNKNOWN;
      end
    end
    return res;
  endfunction

  function automatic req_t build_request(input int unsigned alloc_pct,
                                         input int unsigned big_pct);
    req_t        r;
    int unsigned sel;
    int unsigned pick;
    logic [63:0] hdr;
    hdr = header_len();
    r.request_size = $urandom;
    r.block_address = $urandom;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < alloc_pct) begin
      r.opcode = OP_ALLOC;
      if (sel < 4) begin
        r.request_size = '0;
      end else if (sel < 4 + big_pct) begin
        // Odd draws keep the full random size; even ones fill any room exactly.
        if (!sel[0] && {32'd0, cfg_limit} > {32'd0, break_ptr} + hdr) begin
          r.request_size = 32'({32'd0, cfg_limit} - {32'd0, break_ptr} - hdr);
        end
      end else if (sel < 29 + big_pct && live_count > 0) begin
        pick = $urandom_range(0, live_count - 1);
        r.request_size = blk_size[pick];
      end else begin
        r.request_size = $urandom_range(1, 256);
      end
    end else begin
      r.opcode = OP_FREE;
      if (sel < 5) begin
        r.block_address = '0;
      end else if (sel >= 12 && live_count > 0) begin
        pick = (sel < 40) ? live_count - 1 : $urandom_range(0, live_count - 1);
        r.block_address = 32'({32'd0, blk_start[pick]} + hdr);
        if (sel < 18) r.block_address = r.block_address + (sel[0] ? 32'd1 : 32'hFFFF_FFFF);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin : response_check
    rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("response with no request waiting: addr %h status %0d",
                                  rsp_o.payload_address, rsp_o.status));
      end else begin
        want = pending_responses.pop_front();
        if (rsp_o.payload_address !== want.payload_address)
          report_mismatch($sformatf("payload_address: expected %h, got %h",
                                    want.payload_address, rsp_o.payload_address));
        if (rsp_o.status !== want.status)
          report_mismatch($sformatf("status: expected %0d, got %0d",
                                    want.status, rsp_o.status));
      end
    end
  end

  // Holds start until the request is taken, then leaves start high only
  // when the next request follows without a gap.
  task automatic issue(input req_t r, input bit more, input bit fixed, input rsp_t fixed_rsp);
    rsp_t        want;
    int unsigned gap;
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    want = predict_response(r);
    pending_responses.push_back(fixed ? fixed_rsp : want);
    if (quiet_left > 0) begin
      gap = 0;
      quiet_left--;
    end else begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 24) == 0) quiet_left = $urandom_range(10, 40);
    end
    if (!more) begin
      start <= 1'b0;
    end else if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    wait (pending_responses.size() == 0);
    @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == REG_HEAP_LIMIT) cfg_limit = data;
    else if (idx == REG_HEADER) cfg_header = data[HDR_W-1:0];
  endtask

  task automatic run_phase(input logic [CFG_DAT_W-1:0] limit, input logic [CFG_DAT_W-1:0] hdr,
                           input int unsigned alloc_pct, input int unsigned big_pct,
                           input int unsigned count);
    int unsigned k;
    drain();
    write_reg(REG_HEAP_LIMIT, limit);
    write_reg(REG_HEADER, hdr);
    write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
    cfg_we_i <= 1'b0;
    for (k = 0; k < count; k++)
      issue(build_request(alloc_pct, big_pct), k + 1 < count, 1'b0, '0);
  endtask

  function automatic dir_row_t req_row(input opcode_e op, input logic [31:0] size,
                                       input logic [31:0] addr);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_idx = '0;
    row.cfg_data = '0;
    row.req.opcode = op;
    row.req.request_size = size;
    row.req.block_address = addr;
    row.fixed = 1'b0;
    row.rsp = '0;
    return row;
  endfunction

  function automatic dir_row_t fixed_row(input opcode_e op, input logic [31:0] size,
                                         input logic [31:0] addr, input logic [31:0] pa,
                                         input status_e st);
    dir_row_t row;
    row = req_row(op, size, addr);
    row.fixed = 1'b1;
    row.rsp.payload_address = pa;
    row.rsp.status = st;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DAT_W-1:0] data);
    dir_row_t row;
    row = req_row(OP_ALLOC, '0, '0);
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_data = data;
    return row;
  endfunction

  initial begin : main
    int unsigned i;
    bit          prev_req;
    bit          next_req;
    // Rows start from the reset registers: 64 KiB heap, 24-byte header.
    directed_rows.push_back(fixed_row(OP_ALLOC, 32'd0, 32'd0, 32'd0, ST_NOOP));
    directed_rows.push_back(fixed_row(OP_FREE, 32'hFFFF_FFFF, 32'd0, 32'd0, ST_NOOP));
    directed_rows.push_back(fixed_row(OP_FREE, 32'd0, 32'hFFFF_FFFF, 32'd0, ST_UNKNOWN));
    directed_rows.push_back(fixed_row(OP_ALLOC, 32'hFFFF_FFFF, 32'd0, 32'd0, ST_OOM));
    directed_rows.push_back(fixed_row(OP_ALLOC, 32'd1, 32'hFFFF_FFFF, 32'd24, ST_OK));
    directed_rows.push_back(req_row(OP_ALLOC, 32'd100, 32'd0));
    directed_rows.push_back(req_row(OP_ALLOC, 32'd200, 32'd0));
    directed_rows.push_back(req_row(OP_FREE, 32'd0, 32'd49));
    directed_rows.push_back(req_row(OP_ALLOC, 32'd150, 32'd0));
    directed_rows.push_back(req_row(OP_ALLOC, 32'd100, 32'd0));
    directed_rows.push_back(req_row(OP_FREE, 32'd0, 32'd49));
    directed_rows.push_back(req_row(OP_FREE, 32'd0, 32'd49));
    directed_rows.push_back(fixed_row(OP_FREE, 32'd0, 32'd50, 32'd0, ST_UNKNOWN));
    directed_rows.push_back(req_row(OP_FREE, 32'd0, 32'd397));
    // Removing the tail leaves the free entry below it unmerged.
    directed_rows.push_back(req_row(OP_FREE, 32'd0, 32'd173));
    directed_rows.push_back(fixed_row(OP_ALLOC, 32'd65536, 32'd0, 32'd0, ST_OOM));
    directed_rows.push_back(req_row(OP_ALLOC, 32'd65363, 32'd0));
    directed_rows.push_back(req_row(OP_ALLOC, 32'd1, 32'd0));
    directed_rows.push_back(fixed_row(OP_ALLOC, 32'd1, 32'd0, 32'd0, ST_OOM));
    directed_rows.push_back(req_row(OP_FREE, 32'hFFFF_FFFF, 32'd24));
    directed_rows.push_back(req_row(OP_ALLOC, 32'd1, 32'd0));
    directed_rows.push_back(req_row(OP_FREE, 32'd0, 32'd173));
    // A zero header acts as one byte, so old payload offsets go stale.
    directed_rows.push_back(cfg_row(REG_HEADER, 32'd0));
    directed_rows.push_back(cfg_row(REG_SPARE_2, 32'hFFFF_FFFF));
    directed_rows.push_back(fixed_row(OP_FREE, 32'd0, 32'd24, 32'd0, ST_UNKNOWN));
    directed_rows.push_back(req_row(OP_FREE, 32'd0, 32'd1));
    directed_rows.push_back(cfg_row(REG_HEADER, 32'hFFFF_FFC0));
    directed_rows.push_back(cfg_row(REG_SPARE_3, 32'd0));
    directed_rows.push_back(fixed_row(OP_FREE, 32'd0, 32'd49, 32'd0, ST_UNKNOWN));
    directed_rows.push_back(req_row(OP_FREE, 32'd0, 32'd89));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    prev_req = 1'b0;
    for (i = 0; i < directed_rows.size(); i++) begin
      next_req = (i + 1 < directed_rows.size()) && !directed_rows[i + 1].is_cfg;
      if (directed_rows[i].is_cfg) begin
        if (prev_req) drain();
        write_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_data);
        if (i + 1 >= directed_rows.size() || !directed_rows[i + 1].is_cfg) cfg_we_i <= 1'b0;
        prev_req = 1'b0;
      end else begin
        issue(directed_rows[i].req, next_req, directed_rows[i].fixed, directed_rows[i].rsp);
        prev_req = 1'b1;
      end
    end

    run_phase(32'd65536, 32'd24, 60, 10, 100);
    run_phase(32'd0, 32'd1, 70, 10, 60);
    // Small sizes under an open limit fill the table to its last entry.
    run_phase(32'hFFFF_FFFF, 32'd0, 90, 0, 150);
    run_phase(32'hFFFF_FFFF, 32'd64, 45, 10, 100);
    run_phase(32'd4096, 32'hFFFF_FF7F, 60, 15, 100);
    run_phase($urandom, $urandom, 55, 15, 90);
    run_phase(32'd65536, $urandom_range(1, 64), 50, 10, 100);
    run_phase(32'hFFFF_FFFF, 32'd1, 85, 5, 100);

    drain();
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (mismatch_count != 0 || pending_responses.size() != 0) begin
      $display("CHECKS FAILED");
    end else begin
      $display("ALL CHECKS PASSED");
    end
    $finish;
  end

endmodule
